@@ design/ficpu_pkg.sv @@
// Package for the four-instruction CPU step block.
// Holds store sizing constants, opcodes, the register file type, the execute-stage result struct and the address wrap.
// No dependencies.
`default_nettype none

package ficpu_pkg;

  localparam int ProgramDepth = 64;
  localparam int AddrW        = 6;
  localparam int IdxW         = (ProgramDepth > 1) ? $clog2(ProgramDepth) : 1;
  localparam logic [AddrW:0] DepthLim = (AddrW + 1)'(ProgramDepth);

  typedef enum logic [1:0] {
    OpAdd = 2'b00,
    OpAnd = 2'b01,
    OpNot = 2'b10,
    OpBnz = 2'b11
  } op_t;

  typedef logic [3:0][7:0] regfile_t;

  typedef struct packed {
    logic             wr_en;
    logic [1:0]       dest;
    logic [7:0]       result;
    logic             zero;
    logic [AddrW-1:0] next_pc;
  } exec_res_t;

  function automatic logic [AddrW-1:0] wrap_addr(input logic [AddrW:0] addr);
    logic [AddrW-1:0] res;
    res = (addr < DepthLim) ? addr[AddrW-1:0] : '0;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/four_instruction_cpu_step_top.sv @@
// Four-instruction 8-bit CPU: one load or one step transaction per cycle while in_ready is high.
// A step result appears in the output register in the cycle after acceptance.
// The store is read at the next program counter every cycle, so the word
// for the following step is ready without a bubble; a load to that address
// is forwarded. Reset clears registers, zero flag, counter and output valid;
// store contents stay undefined until loaded. Depends on ficpu_pkg, ficpu_exec.
`default_nettype none

module four_instruction_cpu_step_top
  import ficpu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             action,
  input  wire logic [AddrW-1:0] load_address,
  input  wire logic [7:0]       instruction_word,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [AddrW-1:0]      executed_address,
  output logic [7:0]            executed_word,
  output logic [AddrW-1:0]      next_address,
  output logic                  zero_flag,
  output logic [7:0]            reg_zero,
  output logic [7:0]            reg_one,
  output logic [7:0]            reg_two,
  output logic [7:0]            reg_three
);

  logic [7:0]       store [ProgramDepth];
  logic [7:0]       rd;
  logic             byp_valid;
  logic [7:0]       byp_data;

  logic [AddrW-1:0] pc;
  logic [AddrW-1:0] pc_next;
  regfile_t         regs;
  regfile_t         regs_next;
  logic             zero;
  logic             zero_next;

  logic             in_acc;
  logic             step_fire;
  logic             load_fire;
  logic [7:0]       word;
  exec_res_t        ex;

  assign in_ready  = !out_valid || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign step_fire = in_acc && action;
  assign load_fire = in_acc && !action && ({1'b0, load_address} < DepthLim);
  assign word      = byp_valid ? byp_data : rd;

  ficpu_exec u_exec (
    .word (word),
    .here (pc),
    .regs (regs),
    .zero (zero),
    .res  (ex)
  );

  always_comb begin
    regs_next = regs;
    zero_next = zero;
    pc_next   = pc;
    if (step_fire) begin
      pc_next   = ex.next_pc;
      zero_next = ex.zero;
      if (ex.wr_en) begin
        regs_next[ex.dest] = ex.result;
      end
    end
    if (rst) begin
      pc_next = '0;
    end
  end

  // store: one write port, one registered read at the upcoming counter
  always_ff @(posedge clk) begin
    if (load_fire) begin
      store[load_address[IdxW-1:0]] <= instruction_word;
    end
    rd       <= store[pc_next[IdxW-1:0]];
    byp_data <= instruction_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      regs      <= '0;
      zero      <= 1'b0;
      byp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pc        <= pc_next;
      regs      <= regs_next;
      zero      <= zero_next;
      byp_valid <= load_fire && (load_address == pc_next);
      out_valid <= step_fire || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      executed_address <= pc;
      executed_word    <= word;
      next_address     <= pc_next;
      zero_flag        <= zero_next;
      reg_zero         <= regs_next[0];
      reg_one          <= regs_next[1];
      reg_two          <= regs_next[2];
      reg_three        <= regs_next[3];
    end
  end

endmodule

`default_nettype wire

@@ design/ficpu_exec.sv @@
// Decode and ALU for one instruction word.
// Depends on ficpu_pkg (opcodes, result struct, address wrap).
`default_nettype none

module ficpu_exec
  import ficpu_pkg::*;
(
  input  wire logic [7:0]       word,
  input  wire logic [AddrW-1:0] here,
  input  wire regfile_t         regs,
  input  wire logic             zero,
  output exec_res_t             res
);

  op_t        op;
  logic [1:0] s1;
  logic [1:0] s2;
  logic [7:0] a;
  logic [7:0] b;
  logic [AddrW-1:0] seq_pc;

  assign op     = op_t'(word[7:6]);
  assign s1     = word[5:4];
  assign s2     = word[3:2];
  assign a      = regs[s1];
  assign b      = regs[s2];
  assign seq_pc = wrap_addr({1'b0, here} + (AddrW + 1)'(1));

  always_comb begin
    res.dest    = word[1:0];
    res.wr_en   = 1'b1;
    res.next_pc = seq_pc;
    case (op)
      OpAdd:   res.result = a + b;
      OpAnd:   res.result = a & b;
      OpNot:   res.result = ~a;
      OpBnz: begin
        res.result = 8'h00;
        res.wr_en  = 1'b0;
        if (!zero) begin
          res.next_pc = wrap_addr({1'b0, word[AddrW-1:0]});
        end
      end
      default: res.result = 8'h00;
    endcase
    res.zero = res.wr_en ? (res.result == 8'h00) : zero;
  end

endmodule

`default_nettype wire

@@ design/ficpu_checker.sv @@
// Port-level checks for four_instruction_cpu_step_top, attached by bind.
// Depends on ficpu_pkg (opcodes, address wrap).
`default_nettype none

module ficpu_checker
  import ficpu_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             action,
  input wire logic [AddrW-1:0] load_address,
  input wire logic [7:0]       instruction_word,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [AddrW-1:0] executed_address,
  input wire logic [7:0]       executed_word,
  input wire logic [AddrW-1:0] next_address,
  input wire logic             zero_flag,
  input wire logic [7:0]       reg_zero,
  input wire logic [7:0]       reg_one,
  input wire logic [7:0]       reg_two,
  input wire logic [7:0]       reg_three
);

  logic       is_branch;
  logic [7:0] dest_val;

  assign is_branch = (executed_word[7:6] == OpBnz);

  always_comb begin
    case (executed_word[1:0])
      2'd0:    dest_val = reg_zero;
      2'd1:    dest_val = reg_one;
      2'd2:    dest_val = reg_two;
      default: dest_val = reg_three;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(executed_word)
      && $stable(next_address))
    else $error("result transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_branch |-> zero_flag == (dest_val == 8'h00))
    else $error("zero flag disagrees with destination register");

  a_seq_pc: assert property (@(posedge clk) disable iff (rst)
    out_valid && (!is_branch || zero_flag)
      |-> next_address == wrap_addr({1'b0, executed_address} + (AddrW + 1)'(1)))
    else $error("sequential counter wrong");

  a_branch_pc: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_branch && !zero_flag
      |-> next_address == wrap_addr({1'b0, executed_word[AddrW-1:0]}))
    else $error("branch target wrong");

endmodule

bind four_instruction_cpu_step_top ficpu_checker u_ficpu_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for four_instruction_cpu_step_top: a shadow CPU predicts every step
// transaction, and each result is compared in order against the oldest prediction.
// Depends on ficpu_pkg and the block's RTL.
module testbench;
  import ficpu_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 100;
  localparam logic ActLoad = 1'b0;
  localparam logic ActStep = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0] exec_addr;
    logic [7:0]       exec_word;
    logic [AddrW-1:0] next_addr;
    logic             zero;
    regfile_t         regs;
  } step_report_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             action = ActLoad;
  logic [AddrW-1:0] load_address = '0;
  logic [7:0]       instruction_word = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [AddrW-1:0] executed_address;
  logic [7:0]       executed_word;
  logic [AddrW-1:0] next_address;
  logic             zero_flag;
  logic [7:0]       reg_zero;
  logic [7:0]       reg_one;
  logic [7:0]       reg_two;
  logic [7:0]       reg_three;

  // shadow CPU state
  logic [7:0]       prog_shadow [ProgramDepth];
  bit               loaded [ProgramDepth];
  regfile_t         gpr = '0;
  logic             zf = 1'b0;
  logic [AddrW-1:0] pc = '0;

  step_report_t     expected_reports[$];
  int               errors = 0;
  int               cycle_count = 0;
  int               send_idle_pct = 27;
  int               recv_idle_pct = 65;
  bit               hold_trigger = 1'b0;
  bit               hold_seen = 1'b0;
  int               hold_left = 0;

  four_instruction_cpu_step_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .load_address     (load_address),
    .instruction_word (instruction_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .executed_address (executed_address),
    .executed_word    (executed_word),
    .next_address     (next_address),
    .zero_flag        (zero_flag),
    .reg_zero         (reg_zero),
    .reg_one          (reg_one),
    .reg_two          (reg_two),
    .reg_three        (reg_three)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [AddrW-1:0] fold_address(input int unsigned addr);
    return (addr >= ProgramDepth) ? '0 : addr[AddrW-1:0];
  endfunction

  function automatic step_report_t run_step();
    step_report_t     rep;
    logic [7:0]       word;
    logic [7:0]       val;
    op_t              opcode;
    logic [AddrW-1:0] nxt;
    word   = prog_shadow[pc];
    opcode = op_t'(word[7:6]);
    nxt    = fold_address(int'(pc) + 1);
    val    = '0;
    case (opcode)
      OpAdd: val = gpr[word[5:4]] + gpr[word[3:2]];
      OpAnd: val = gpr[word[5:4]] & gpr[word[3:2]];
      OpNot: val = ~gpr[word[5:4]];
      default: val = '0;
    endcase
    if (opcode == OpBnz) begin
      if (!zf) nxt = fold_address(int'(word[5:0]));
    end else begin
      gpr[word[1:0]] = val;
      zf = (val == 8'h00);
    end
    rep.exec_addr = pc;
    rep.exec_word = word;
    rep.next_addr = nxt;
    rep.zero      = zf;
    rep.regs      = gpr;
    pc = nxt;
    return rep;
  endfunction

  // branches mostly land inside the active program region
  function automatic logic [7:0] random_word(input int span);
    logic [7:0] w;
    w = 8'($urandom_range(255));
    if (w[7:6] == OpBnz && $urandom_range(3) != 0) w[5:0] = 6'($urandom_range(span - 1));
    return w;
  endfunction

  task automatic send_item(input logic act, input logic [AddrW-1:0] addr,
                           input logic [7:0] word);
    int           gap;
    step_report_t rep;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    action           <= act;
    load_address     <= addr;
    instruction_word <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ActStep) begin
      rep = run_step();
      expected_reports = {expected_reports, rep};
    end else if (addr < ProgramDepth) begin
      prog_shadow[addr] = word;
      loaded[addr]      = 1'b1;
    end
  endtask

  // never execute an entry that was not loaded
  task automatic step_cpu(input int span);
    if (!loaded[pc]) send_item(ActLoad, pc, random_word(span));
    send_item(ActStep, 6'($urandom_range(63)), 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic check_report();
    step_report_t exp;
    if (expected_reports.size() == 0) begin
      $display("%0t: executed_address expected none actual %0h", $time, executed_address);
      errors++;
    end else begin
      exp = expected_reports.pop_front();
      check_field("executed_address", 8'(exp.exec_addr), 8'(executed_address));
      check_field("executed_word", exp.exec_word, executed_word);
      check_field("next_address", 8'(exp.next_addr), 8'(next_address));
      check_field("zero_flag", 8'(exp.zero), 8'(zero_flag));
      check_field("reg_zero", exp.regs[0], reg_zero);
      check_field("reg_one", exp.regs[1], reg_one);
      check_field("reg_two", exp.regs[2], reg_two);
      check_field("reg_three", exp.regs[3], reg_three);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_report();
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // every opcode, zero flag set and cleared, branch taken and not taken,
  // add wrap, counter wrap from the top address, load straight before its step
  task automatic test_directed();
    logic [AddrW-1:0] dir_addr [9];
    logic [7:0]       dir_word [9];
    dir_addr = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd63};
    dir_word = '{8'b10_00_11_01, 8'b00_01_01_10, 8'b01_01_10_11, 8'b10_10_00_00,
                 8'b00_00_01_11, 8'b11_000000, 8'b10_11_00_11, 8'b11_111111,
                 8'b00_00_00_00};
    for (int i = 0; i < 9; i++) begin
      send_item(ActLoad, dir_addr[i], dir_word[i]);
      step_cpu(8);
    end
    step_cpu(8);
    send_item(ActStep, 6'h3F, 8'hFF);
    send_item(ActStep, 6'h00, 8'h00);
  endtask

  task automatic test_random(input int count, input int span);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 12) send_item(ActLoad, 6'($urandom_range(63)), random_word(span));
      else if (pick < 22) send_item(ActLoad, pc, random_word(span));
      else if (pick < 30) send_item(ActLoad, 6'($urandom_range(span - 1)), random_word(span));
      else step_cpu(span);
    end
  endtask

  task automatic test_backpressure();
    int saved;
    saved         = send_idle_pct;
    send_idle_pct = 0;
    hold_trigger  = ~hold_trigger;
    repeat (40) step_cpu(16);
    send_idle_pct = saved;
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(100, 8);
    wait_drained();
    send_idle_pct = 65;
    recv_idle_pct = 27;
    test_random(100, 16);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(100, 64);
    test_backpressure();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
